### design/lru_page_replacement_core_macros.svh
// assertion helpers shared by the lru page replacement modules
`ifndef LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LRUPR_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrupr: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LRUPR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrupr: next-cycle check failed");

`endif

### design/lrupr_pkg.sv
package lrupr_pkg;

  localparam int WAYS_DEFAULT      = 64;
  localparam int PAGE_BITS_DEFAULT = 16;

  localparam int PAGE_W = 16;
  localparam int SLOT_W = 6;
  localparam int HIT_W  = 32;
  localparam int CFG_W  = 7;
  localparam int AGE_W  = 6;
  localparam int AGES   = 1 << AGE_W;
  localparam int OUT_W  = 1 + SLOT_W + 1 + PAGE_W + HIT_W;

  localparam logic [CFG_W-1:0] WAYS_RESET = CFG_W'(64);
  localparam logic [AGE_W-1:0] AGE_MAX    = '1;

  // result word bit positions
  localparam int OUT_HIT  = 0;
  localparam int OUT_EVV  = 1 + SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic select;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### design/lrupr_ctrl.sv
`include "lru_page_replacement_core_macros.svh"

module lrupr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  lrupr_pkg::sts_t sts,
  output lrupr_pkg::cmd_t cmd
);

  lrupr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lrupr_pkg::ST_SELECT;
      end
      lrupr_pkg::ST_SELECT: begin
        state_next = lrupr_pkg::ST_UPDATE;
      end
      lrupr_pkg::ST_UPDATE: begin
        if (sts.out_free) state_next = lrupr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.select  = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      lrupr_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
      end
      lrupr_pkg::ST_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // an update that finds the output register free always ends the access
  `LRUPR_ASSERT_NEXT(a_update_done, clk, rst,
    (state == lrupr_pkg::ST_UPDATE) && sts.out_free, state == lrupr_pkg::ST_IDLE)

endmodule

### design/lrupr_dp.sv
`include "lru_page_replacement_core_macros.svh"

module lrupr_dp #(
  parameter int WAYS      = lrupr_pkg::WAYS_DEFAULT,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [lrupr_pkg::PAGE_W-1:0]  s_tdata,
  input  lrupr_pkg::cmd_t               cmd,
  output lrupr_pkg::sts_t               sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lrupr_pkg::OUT_W-1:0]   m_tdata
);

  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W;
  localparam int AGE_W = lrupr_pkg::AGE_W;
  localparam int AGES  = lrupr_pkg::AGES;

  logic [lrupr_pkg::CFG_W-1:0] ways_cfg;
  logic [WAYS-1:0]             inuse;

  // slot cells, each compared in parallel
  logic [TAG_W-1:0] slot_page [WAYS];
  logic [AGE_W-1:0] slot_age  [WAYS];
  logic [WAYS-1:0]  slot_valid;
  logic [lrupr_pkg::HIT_W-1:0] hit_counter;

  // lookup results
  logic [WAYS-1:0]  match_c, free_c;
  logic [AGES-1:0]  age_seen_c;
  logic [TAG_W-1:0] page_q;
  logic [WAYS-1:0]  match_q, free_q;
  logic [AGES-1:0]  age_seen_q;

  // selection results
  logic             hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx, victim_idx;
  logic [AGE_W-1:0] vage;
  logic             sel_hit, sel_full, age_all;
  logic [IDX_W-1:0] target_q;
  logic [AGE_W-1:0] ref_q;
  logic [lrupr_pkg::PAGE_W-1:0] evict_q;

  logic [lrupr_pkg::HIT_W-1:0] hit_counter_next;
  logic                        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_cfg <= lrupr_pkg::WAYS_RESET;
    end else if (cfg_wen) begin
      ways_cfg <= cfg_wdata;
    end
  end

  // zero ways acts as one, anything above WAYS is cut off by the vector width
  for (genvar g = 0; g < WAYS; g++) begin : g_inuse
    assign inuse[g] = (g == 0) || (32'(ways_cfg) > g);
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match_c[i] = inuse[i] && slot_valid[i] && (slot_page[i] == s_tdata[TAG_W-1:0]);
      free_c[i]  = inuse[i] && !slot_valid[i];
    end
    for (int a = 0; a < AGES; a++) begin
      age_seen_c[a] = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (inuse[i] && slot_valid[i] && (slot_age[i] == AGE_W'(a))) age_seen_c[a] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q     <= s_tdata[TAG_W-1:0];
      match_q    <= match_c;
      free_q     <= free_c;
      age_seen_q <= age_seen_c;
    end
  end

  // lowest hit, lowest free slot, oldest age, lowest slot of that age
  always_comb begin
    hit_any    = |match_q;
    free_any   = |free_q;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    vage       = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IDX_W'(i);
      if (free_q[i])  free_idx = IDX_W'(i);
    end
    for (int a = 0; a < AGES; a++) begin
      if (age_seen_q[a]) vage = AGE_W'(a);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (inuse[i] && (slot_age[i] == vage)) victim_idx = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      sel_hit  <= hit_any;
      sel_full <= !hit_any && !free_any;
      age_all  <= !hit_any && free_any;
      priority if (hit_any) begin
        target_q <= hit_idx;
        ref_q    <= slot_age[hit_idx];
        evict_q  <= '0;
      end else if (free_any) begin
        target_q <= free_idx;
        ref_q    <= vage;
        evict_q  <= '0;
      end else begin
        target_q <= victim_idx;
        ref_q    <= vage;
        evict_q  <= lrupr_pkg::PAGE_W'(slot_page[victim_idx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.update) begin
      slot_valid[target_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < WAYS; i++) begin
        if (target_q == IDX_W'(i)) begin
          slot_page[i] <= page_q;
          slot_age[i]  <= '0;
        end else if (inuse[i] && slot_valid[i] && (age_all || (slot_age[i] < ref_q))) begin
          slot_age[i] <= (slot_age[i] == lrupr_pkg::AGE_MAX) ? lrupr_pkg::AGE_MAX
                                                             : slot_age[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    hit_counter_next = hit_counter;
    if (sel_hit && (hit_counter != '1)) hit_counter_next = hit_counter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.update) begin
        hit_counter <= hit_counter_next;
        out_valid   <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      m_tdata <= {hit_counter_next, evict_q, sel_full, lrupr_pkg::SLOT_W'(target_q), sel_hit};
    end
  end

  assign m_tvalid     = out_valid;
  assign sts.out_free = !out_valid || m_tready;

  // a resident slot is never dropped
  `LRUPR_ASSERT_NEXT(a_valid_sticky, clk, rst, 1'b1,
    (slot_valid & $past(slot_valid)) == $past(slot_valid))
  // a fill without eviction lands on a free slot
  `LRUPR_ASSERT_NOW(a_fill_free, clk, rst,
    cmd.update && !sel_hit && !sel_full, !slot_valid[target_q])
  // the hit count never goes backward
  `LRUPR_ASSERT_NEXT(a_hit_mono, clk, rst, 1'b1, hit_counter >= $past(hit_counter))

endmodule

### design/lru_page_replacement_core.sv
// the result word is registered by the update step, after the capture and select steps
// accesses: a new access word is taken only after the capture, select and update
//   steps that share the slot array are done; a stalled result word holds the update step
// reset: synchronous; all slots empty, hit count zero, ways in use 64,
//   no clearing pass
`include "lru_page_replacement_core_macros.svh"

module lru_page_replacement_core #(
  parameter int WAYS      = lrupr_pkg::WAYS_DEFAULT,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_wdata,   // ways_in_use
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lrupr_pkg::PAGE_W-1:0] s_tdata,     // page_number
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit, slot, evicted_valid, evicted_page, hit_total
  output logic [lrupr_pkg::OUT_W-1:0]  m_tdata
);

  lrupr_pkg::cmd_t cmd;
  lrupr_pkg::sts_t sts;

  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrupr_dp #(
    .WAYS      (WAYS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // a hit never reports an eviction
  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk, rst, m_tvalid,
    !(m_tdata[lrupr_pkg::OUT_HIT] && m_tdata[lrupr_pkg::OUT_EVV]))

endmodule

### verif/tb_lru_page_replacement_core.sv
`timescale 1ns / 100ps

module tb_lru_page_replacement_core;

  localparam int N_WAYS      = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 6;

  // result word, hit in bit 0
  typedef struct packed {
    logic [lrupr_pkg::HIT_W-1:0]  hit_total;
    logic [lrupr_pkg::PAGE_W-1:0] evicted_page;
    logic                         evicted_valid;
    logic [lrupr_pkg::SLOT_W-1:0] slot;
    logic                         hit;
  } access_result_t;

  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         cfg_wen   = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [lrupr_pkg::PAGE_W-1:0] s_tdata   = '0;   // page_number
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  // hit, slot, evicted_valid, evicted_page, hit_total
  logic [lrupr_pkg::OUT_W-1:0]  m_tdata;

  // shadow copy of the page table
  logic [lrupr_pkg::PAGE_W-1:0] tab_page  [N_WAYS];
  logic                         tab_valid [N_WAYS];
  logic [lrupr_pkg::AGE_W-1:0]  tab_age   [N_WAYS];
  logic [lrupr_pkg::HIT_W-1:0]  hit_count    = '0;
  logic [lrupr_pkg::CFG_W-1:0]  ways_setting = lrupr_pkg::WAYS_RESET;

  access_result_t pending_results[$];

  int send_idle_pct = 20;
  int recv_idle_pct = 66;
  int errors        = 0;
  int stall_cycles  = 0;

  lru_page_replacement_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < N_WAYS; i++) begin
      tab_page[i]  = '0;
      tab_valid[i] = 1'b0;
      tab_age[i]   = '0;
    end
  end

  function automatic logic [lrupr_pkg::AGE_W-1:0] age_up(
    input logic [lrupr_pkg::AGE_W-1:0] a
  );
    return (a == lrupr_pkg::AGE_MAX) ? lrupr_pkg::AGE_MAX : a + 1'b1;
  endfunction

  function automatic access_result_t predict_access(input logic [lrupr_pkg::PAGE_W-1:0] pg);
    int                          w;
    int                          i;
    int                          found;
    int                          target;
    int                          victim;
    logic [lrupr_pkg::AGE_W-1:0] ref_age;
    access_result_t              r;
    // out of range settings clamp to 1..N_WAYS
    if (ways_setting == 0)
      w = 1;
    else if (ways_setting > N_WAYS)
      w = N_WAYS;
    else
      w = int'(ways_setting);
    r = '0;
    found = -1;
    for (i = 0; i < w; i++)
      if (found < 0 && tab_valid[i] && tab_page[i] == pg)
        found = i;
    if (found >= 0) begin
      ref_age = tab_age[found];
      for (i = 0; i < w; i++)
        if (i != found && tab_valid[i] && tab_age[i] < ref_age)
          tab_age[i] = age_up(tab_age[i]);
      tab_age[found] = '0;
      if (hit_count != '1)
        hit_count = hit_count + 1'b1;
      r.hit = 1'b1;
      target = found;
    end else begin
      target = -1;
      for (i = 0; i < w; i++)
        if (target < 0 && !tab_valid[i])
          target = i;
      if (target >= 0) begin
        for (i = 0; i < w; i++)
          if (tab_valid[i])
            tab_age[i] = age_up(tab_age[i]);
      end else begin
        // full window: oldest slot goes, lowest index on a tie
        victim = 0;
        for (i = 1; i < w; i++)
          if (tab_age[i] > tab_age[victim])
            victim = i;
        ref_age = tab_age[victim];
        for (i = 0; i < w; i++)
          if (i != victim && tab_age[i] < ref_age)
            tab_age[i] = age_up(tab_age[i]);
        r.evicted_valid = 1'b1;
        r.evicted_page  = tab_page[victim];
        target = victim;
      end
      tab_page[target]  = pg;
      tab_valid[target] = 1'b1;
      tab_age[target]   = '0;
    end
    r.slot      = target[lrupr_pkg::SLOT_W-1:0];
    r.hit_total = hit_count;
    return r;
  endfunction

  task automatic send_page(input logic [lrupr_pkg::PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pg;
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, predict_access(pg)};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ways(input logic [lrupr_pkg::CFG_W-1:0] val);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    ways_setting = val;
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with no access pending: %h", $time, m_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_page !== want.evicted_page ||
              got.hit_total !== want.hit_total) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp hit=%0d slot=%0d ev=%0d/%h total=%0d,",
                       $time, want.hit, want.slot, want.evicted_valid, want.evicted_page,
                       want.hit_total,
                       " got hit=%0d slot=%0d ev=%0d/%h total=%0d",
                       got.hit, got.slot, got.evicted_valid,
                       got.evicted_page, got.hit_total);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_fill_and_hit();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h8001);
    send_page(16'h7FFE);
    send_page(16'hFFFF);
    send_page(16'h0001);
  endtask

  // a page left outside a narrowed window gets a second copy; the lower one must hit
  task automatic test_duplicate_after_regrow();
    write_ways(7'd2);
    send_page(16'h7FFE);
    write_ways(7'd64);
    send_page(16'h7FFE);
    send_page(16'h1234);
  endtask

  task automatic test_ways_clamping();
    write_ways(7'd0);
    send_page(16'h00FF);
    send_page(16'h00FF);
    send_page(16'hFF00);
    write_ways(7'd127);
    send_page(16'hFF00);
    send_page(16'h4444);
    send_page(16'h00FF);
    write_ways(7'd1);
    send_page(16'h4444);
    send_page(16'h5555);
    send_page(16'h5555);
  endtask

  // working set a little larger than the window, with some random pages
  task automatic test_random_traffic(input logic [lrupr_pkg::CFG_W-1:0] ways_val,
                                     input int pool_n, input int n_items);
    logic [lrupr_pkg::PAGE_W-1:0] pool[$];
    int                           k;
    write_ways(ways_val);
    for (k = 0; k < pool_n; k++)
      pool = {pool, lrupr_pkg::PAGE_W'($urandom_range(0, 65535))};
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 75)
        send_page(pool[$urandom_range(0, pool_n - 1)]);
      else
        send_page(lrupr_pkg::PAGE_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_hit();
    test_duplicate_after_regrow();
    test_ways_clamping();
    send_idle_pct = 20;
    recv_idle_pct = 66;
    test_random_traffic(7'd64, 72, 150);
    test_random_traffic(7'd3, 5, 100);
    send_idle_pct = 66;
    recv_idle_pct = 20;
    test_random_traffic(7'd127, 90, 150);
    test_random_traffic(7'd1, 3, 80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(7'd0, 2, 80);
    test_random_traffic(7'd64, 80, 190);
    drain();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
